// ===== src/tlvd_pkg.sv =====
`default_nettype none

package tlvd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 32;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned TAG_W   = 8;
    localparam int unsigned LSEEN_W = 2;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 32'd67108864;

    typedef enum logic [KIND_W-1:0] {
        KIND_TAGLEN  = 3'd0,
        KIND_TAG     = 3'd1,
        KIND_LEN     = 3'd2,
        KIND_PAYLOAD = 3'd3,
        KIND_DISCARD = 3'd4
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        kind_t             kind;
        logic              frame_end;
        logic              length_error;
        logic [LEN_W-1:0]  payload_length;
    } result_t;

endpackage

`default_nettype wire

// ===== src/tlv_frame_deframer.sv =====
// Tag/length/value deframer: classifies every byte of a framed stream.
//
// Input channel in_valid/in_ready carries data_byte, one byte per transfer.
// Output channel out_valid/out_ready carries one result per input byte:
// byte_out, byte_kind, frame_end, length_error and payload_length.
// Config channel cfg_valid/cfg_ready writes max_payload; cfg_ready is
// always high. Write it only while no byte is in flight.
//
// A byte passes through the input register, then the classifier feeding
// the result register, which drives out_valid. One byte per cycle is
// sustained while out_ready is high, bounded by the single frame state
// update per byte.
//
// Reset clears both stages and the frame state, and sets max_payload to
// 64 MiB. A length above max_payload flags length_error and every later
// byte is marked discarded until the next reset.
// When the receiver stalls the result register holds, the input register
// fills, and in_ready drops once both are occupied.
`default_nettype none

module tlv_frame_deframer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [tlvd_pkg::BYTE_W-1:0] data_byte,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [tlvd_pkg::BYTE_W-1:0]      byte_out,
    output logic [tlvd_pkg::KIND_W-1:0]      byte_kind,
    output logic                             frame_end,
    output logic                             length_error,
    output logic [tlvd_pkg::LEN_W-1:0]       payload_length,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [tlvd_pkg::LEN_W-1:0]  max_payload
);
    import tlvd_pkg::*;

    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              out_free;
    logic              advance;
    logic [LEN_W-1:0]  max_payload_reg;
    result_t           result;

    assign cfg_ready = 1'b1;
    assign advance   = held_valid && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_payload_reg <= max_payload;
        end
    end

    tlvd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    tlvd_classify u_classify (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .held_byte   (held_byte),
        .max_payload (max_payload_reg),
        .result      (result)
    );

    tlvd_out_stage u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (advance),
        .result         (result),
        .free           (out_free),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .byte_out       (byte_out),
        .byte_kind      (byte_kind),
        .frame_end      (frame_end),
        .length_error   (length_error),
        .payload_length (payload_length)
    );

    a_lerr_on_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && length_error |-> byte_kind == KIND_LEN && !frame_end)
        else $error("length_error on a byte that is not a length byte");

    a_fend_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> byte_kind == KIND_LEN || byte_kind == KIND_PAYLOAD)
        else $error("frame_end on a byte that cannot close a frame");

    a_plen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_kind == KIND_TAGLEN || byte_kind == KIND_TAG
                      || byte_kind == KIND_DISCARD) |-> payload_length == '0)
        else $error("payload_length set outside length or payload bytes");

    a_no_stall_drop: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid && !out_free |=> held_valid)
        else $error("held byte lost while output stalled");

endmodule

`default_nettype wire

// ===== src/tlvd_in_stage.sv =====
`default_nettype none

module tlvd_in_stage (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [tlvd_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                       advance,
    output logic                            held_valid,
    output logic [tlvd_pkg::BYTE_W-1:0]     held_byte
);
    import tlvd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // take a new byte when empty or when the held one moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

`default_nettype wire

// ===== src/tlvd_classify.sv =====
`default_nettype none

module tlvd_classify (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire logic [tlvd_pkg::BYTE_W-1:0] held_byte,
    input  wire logic [tlvd_pkg::LEN_W-1:0]  max_payload,
    output tlvd_pkg::result_t                result
);
    import tlvd_pkg::*;

    typedef enum logic [2:0] {
        PH_TAGLEN,
        PH_TAG,
        PH_LEN,
        PH_PAYLOAD,
        PH_DISCARD
    } phase_t;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [TAG_W-1:0]     tag_left_reg;
    logic [TAG_W-1:0]     tag_left_next;
    logic [LSEEN_W-1:0]   len_seen_reg;
    logic [LSEEN_W-1:0]   len_seen_next;
    logic [LEN_W-1:0]     len_acc_reg;
    logic [LEN_W-1:0]     len_acc_next;
    logic [LEN_W-1:0]     pay_left_reg;
    logic [LEN_W-1:0]     pay_left_next;
    logic [LEN_W-1:0]     acc_shift;

    assign acc_shift = {len_acc_reg[LEN_W-BYTE_W-1:0], held_byte};

    always_comb
    begin
        phase_next            = phase_reg;
        tag_left_next         = tag_left_reg;
        len_seen_next         = len_seen_reg;
        len_acc_next          = len_acc_reg;
        pay_left_next         = pay_left_reg;
        result.data           = held_byte;
        result.kind           = KIND_DISCARD;
        result.frame_end      = 1'b0;
        result.length_error   = 1'b0;
        result.payload_length = '0;

        case (phase_reg)
            PH_TAGLEN:
            begin
                result.kind   = KIND_TAGLEN;
                tag_left_next = held_byte;
                len_seen_next = '0;
                len_acc_next  = '0;
                pay_left_next = '0;
                phase_next    = (held_byte != '0) ? PH_TAG : PH_LEN;
            end
            PH_TAG:
            begin
                result.kind   = KIND_TAG;
                tag_left_next = tag_left_reg - 1'b1;
                if (tag_left_reg == TAG_W'(1))
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                result.kind  = KIND_LEN;
                len_acc_next = acc_shift;
                if (len_seen_reg == '1)
                begin
                    len_seen_next         = '0;
                    result.payload_length = acc_shift;
                    if (acc_shift > max_payload)
                    begin
                        // sticky until reset
                        result.length_error = 1'b1;
                        phase_next          = PH_DISCARD;
                    end
                    else if (acc_shift == '0)
                    begin
                        result.frame_end = 1'b1;
                        phase_next       = PH_TAGLEN;
                    end
                    else
                    begin
                        pay_left_next = acc_shift;
                        phase_next    = PH_PAYLOAD;
                    end
                end
                else
                begin
                    len_seen_next = len_seen_reg + 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                result.kind           = KIND_PAYLOAD;
                result.payload_length = len_acc_reg;
                pay_left_next         = pay_left_reg - 1'b1;
                if (pay_left_reg == LEN_W'(1))
                begin
                    result.frame_end = 1'b1;
                    phase_next       = PH_TAGLEN;
                end
            end
            default:
            begin
                phase_next = PH_DISCARD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TAGLEN;
            tag_left_reg <= '0;
            len_seen_reg <= '0;
            len_acc_reg  <= '0;
            pay_left_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            tag_left_reg <= tag_left_next;
            len_seen_reg <= len_seen_next;
            len_acc_reg  <= len_acc_next;
            pay_left_reg <= pay_left_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/tlvd_out_stage.sv =====
`default_nettype none

module tlvd_out_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire tlvd_pkg::result_t           result,
    output logic                             free,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [tlvd_pkg::BYTE_W-1:0]      byte_out,
    output logic [tlvd_pkg::KIND_W-1:0]      byte_kind,
    output logic                             frame_end,
    output logic                             length_error,
    output logic [tlvd_pkg::LEN_W-1:0]       payload_length
);
    import tlvd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // free when empty or when the current result is taken this cycle
    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign out_valid      = valid_reg;
    assign byte_out       = res_reg.data;
    assign byte_kind      = res_reg.kind;
    assign frame_end      = res_reg.frame_end;
    assign length_error   = res_reg.length_error;
    assign payload_length = res_reg.payload_length;

endmodule

`default_nettype wire
